@@ sv/ura_pkg.sv @@
// shared types and constants for the ultrasonic range alert core
// no dependencies; imported by ultrasonic_range_alert_core

package ura_pkg;

    // configuration register widths
    localparam int IdleGapW   = 20;
    localparam int TrigLowW   = 8;
    localparam int TrigHighW  = 8;
    localparam int TimeoutW   = 16;
    localparam int UnitW      = 16;
    localparam int ThreshW    = 16;
    localparam int CfgDataW   = 20;
    localparam int CfgIndexW  = 3;
    localparam int PhaseTickW = 20;
    localparam int DistW      = 16;

    // reset values of the configuration registers
    localparam logic [IdleGapW-1:0]  IdleGapRst  = IdleGapW'(500000);
    localparam logic [TrigLowW-1:0]  TrigLowRst  = TrigLowW'(2);
    localparam logic [TrigHighW-1:0] TrigHighRst = TrigHighW'(10);
    localparam logic [TimeoutW-1:0]  TimeoutRst  = TimeoutW'(50000);
    localparam logic [UnitW-1:0]     UnitRst     = UnitW'(15);
    localparam logic [ThreshW-1:0]   ThreshRst   = ThreshW'(50);

    // configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        CFG_IDLE_GAP   = 3'd0,
        CFG_TRIG_LOW   = 3'd1,
        CFG_TRIG_HIGH  = 3'd2,
        CFG_TIMEOUT    = 3'd3,
        CFG_UNIT       = 3'd4,
        CFG_THRESHOLD  = 3'd5
    } cfg_index_t;

    // one result item
    typedef struct packed {
        logic             trigger_level;
        logic             alert_on;
        logic [DistW-1:0] distance_units;
        logic             stop_flag;
        logic             measure_done;
        logic             measure_error;
    } result_t;

endpackage

@@ sv/ultrasonic_range_alert_core.sv @@
// ultrasonic ranging sequencer with proximity alert, one echo sample per tick
// a result is registered in the output register, or in the skid entry while the output is held
// one tick per cycle unless in_stall; a two-entry output (register + skid) decouples stalls
// reset (rst_n, async, active low): idle gap phase, counters and stored distance cleared,
// alert off, configuration registers back to their defaults, no result pending
// depends on ura_pkg

module ultrasonic_range_alert_core
    import ura_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // tick channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 echo_level,

    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 trigger_level,
    output logic                 alert_on,
    output logic [DistW-1:0]     distance_units,
    output logic                 stop_flag,
    output logic                 measure_done,
    output logic                 measure_error,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // measurement phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_RISE  = 3'd3,
        PH_FALL  = 3'd4
    } phase_t;

    // configuration registers
    logic [IdleGapW-1:0]   idle_gap_reg;
    logic [TrigLowW-1:0]   trig_low_reg;
    logic [TrigHighW-1:0]  trig_high_reg;
    logic [TimeoutW-1:0]   timeout_reg;
    logic [UnitW-1:0]      unit_reg;
    logic [ThreshW-1:0]    thresh_reg;

    // sequencer state
    phase_t                phase_reg, phase_next;
    logic [PhaseTickW-1:0] phase_ticks_reg, phase_ticks_next;
    logic [UnitW-1:0]      prescale_reg, prescale_next;
    logic [DistW-1:0]      echo_units_reg, echo_units_next;
    logic [DistW-1:0]      distance_reg, distance_next;
    logic                  alert_reg, alert_next;

    // output register and skid entry
    result_t               out_reg, skid_reg, result;
    logic                  out_valid_reg, skid_valid_reg;

    logic                  in_xfer;
    logic                  out_xfer;
    logic [PhaseTickW-1:0] tick_inc;
    logic [UnitW:0]        prescale_inc;
    logic                  done;
    logic                  err;
    logic                  trig;

    // a tick is taken whenever the skid entry is free
    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && !skid_valid_reg;
    assign out_xfer = out_valid_reg && !out_stall;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_gap_reg  <= IdleGapRst;
            trig_low_reg  <= TrigLowRst;
            trig_high_reg <= TrigHighRst;
            timeout_reg   <= TimeoutRst;
            unit_reg      <= UnitRst;
            thresh_reg    <= ThreshRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDLE_GAP:  idle_gap_reg  <= cfg_data[IdleGapW-1:0];
                CFG_TRIG_LOW:  trig_low_reg  <= cfg_data[TrigLowW-1:0];
                CFG_TRIG_HIGH: trig_high_reg <= cfg_data[TrigHighW-1:0];
                CFG_TIMEOUT:   timeout_reg   <= cfg_data[TimeoutW-1:0];
                CFG_UNIT:      unit_reg      <= cfg_data[UnitW-1:0];
                CFG_THRESHOLD: thresh_reg    <= cfg_data[ThreshW-1:0];
                default:       ;
            endcase
        end
    end

    // one tick of the sequencer; limit compares use the incremented count,
    // so a limit of zero behaves like one and a lowered limit ends the phase at once
    always_comb
    begin
        tick_inc         = phase_ticks_reg + PhaseTickW'(1);
        prescale_inc     = {1'b0, prescale_reg} + (UnitW+1)'(1);
        phase_next       = phase_reg;
        phase_ticks_next = tick_inc;
        prescale_next    = prescale_reg;
        echo_units_next  = echo_units_reg;
        distance_next    = distance_reg;
        alert_next       = alert_reg;
        done             = 1'b0;
        err              = 1'b0;
        trig             = 1'b0;

        unique case (phase_reg)
            PH_TLOW:
            begin
                if (tick_inc >= PhaseTickW'(trig_low_reg))
                begin
                    phase_next       = PH_THIGH;
                    phase_ticks_next = '0;
                end
            end
            PH_THIGH:
            begin
                trig = 1'b1;
                if (tick_inc >= PhaseTickW'(trig_high_reg))
                begin
                    phase_next       = PH_RISE;
                    phase_ticks_next = '0;
                end
            end
            PH_RISE:
            begin
                if (echo_level)
                begin
                    // rising edge tick is not counted
                    phase_next       = PH_FALL;
                    phase_ticks_next = '0;
                    prescale_next    = '0;
                    echo_units_next  = '0;
                end
                else if (tick_inc >= PhaseTickW'(timeout_reg))
                begin
                    done = 1'b1;
                    err  = 1'b1;
                end
            end
            PH_FALL:
            begin
                if (!echo_level)
                begin
                    done = 1'b1;
                end
                else
                begin
                    // prescaler: one unit per ticks_per_unit high ticks, saturating
                    if (prescale_inc >= (UnitW+1)'(unit_reg))
                    begin
                        prescale_next = '0;
                        if (echo_units_reg != '1)
                        begin
                            echo_units_next = echo_units_reg + DistW'(1);
                        end
                    end
                    else
                    begin
                        prescale_next = prescale_inc[UnitW-1:0];
                    end
                    if (tick_inc >= PhaseTickW'(timeout_reg))
                    begin
                        done = 1'b1;
                        err  = 1'b1;
                    end
                end
            end
            default:
            begin
                // idle gap; unused codes fall back here
                phase_next = PH_IDLE;
                if (tick_inc >= idle_gap_reg)
                begin
                    phase_next       = (trig_low_reg != '0) ? PH_TLOW : PH_THIGH;
                    phase_ticks_next = '0;
                end
            end
        endcase

        // end of measurement: store a positive distance, else drop the alert
        if (done)
        begin
            if (!err && echo_units_next != '0)
            begin
                distance_next = echo_units_next;
                alert_next    = (echo_units_next < thresh_reg);
            end
            else
            begin
                alert_next = 1'b0;
            end
            phase_next       = PH_IDLE;
            phase_ticks_next = '0;
            prescale_next    = '0;
        end

        result.trigger_level  = trig;
        result.alert_on       = alert_next;
        result.distance_units = distance_next;
        result.stop_flag      = (distance_next < thresh_reg);
        result.measure_done   = done;
        result.measure_error  = err;
    end

    // sequencer state advances only on a tick transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            prescale_reg    <= '0;
            echo_units_reg  <= '0;
            distance_reg    <= '0;
            alert_reg       <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            prescale_reg    <= prescale_next;
            echo_units_reg  <= echo_units_next;
            distance_reg    <= distance_next;
            alert_reg       <= alert_next;
        end
    end

    // output valids: the skid entry fills only when the output register is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_xfer || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || in_xfer;
            skid_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_xfer || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_xfer)
            begin
                out_reg <= result;
            end
        end
        else if (in_xfer)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_level  = out_reg.trigger_level;
    assign alert_on       = out_reg.alert_on;
    assign distance_units = out_reg.distance_units;
    assign stop_flag      = out_reg.stop_flag;
    assign measure_done   = out_reg.measure_done;
    assign measure_error  = out_reg.measure_error;

    // skid entry is only ever occupied behind a held output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry occupied with empty output register");

    // an error is only reported on the tick that ends a measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_reg.measure_error || out_reg.measure_done))
        else $error("measure_error without measure_done");

    // trigger pulse never coincides with the end of a measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.trigger_level) |-> !out_reg.measure_done)
        else $error("trigger high on a measurement end tick");

    // a tick in the trigger high phase always drives the trigger in its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && phase_reg == PH_THIGH && !skid_valid_reg && (out_xfer || !out_valid_reg))
        |=> (out_valid_reg && out_reg.trigger_level))
        else $error("trigger not driven during trigger high phase");

endmodule
